[rtl/battery_discharge_capacity_meter_assert.svh]
// assertion macros shared by the discharge meter modules
`ifndef BATTERY_DISCHARGE_CAPACITY_METER_ASSERT_SVH
`define BATTERY_DISCHARGE_CAPACITY_METER_ASSERT_SVH

// same-cycle implication, clocked on clock and held off during reset
`define BDCM_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bdcm: assertion failed");

// next-cycle implication, clocked on clock and held off during reset
`define BDCM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bdcm: assertion failed");

`endif

[rtl/bdcm_pkg.sv]
// shared types, constants and helpers of the discharge capacity meter
package bdcm_pkg;

   // field widths
   localparam int ADC_W  = 12;
   localparam int UV_W   = 23;
   localparam int CAP_W  = 21;
   localparam int MIN_W  = 16;
   localparam int SEC_W  = 6;
   localparam int ADDR_W = 10;
   localparam int VAL_W  = 16;
   localparam int RES_W  = 16;
   localparam int SUM_W  = 26;
   localparam int CHG_W  = 32;

   // log storage depth and slot counter
   localparam int LOG_DEPTH = 1024;
   localparam int SLOT_W    = (LOG_DEPTH > 2) ? $clog2(LOG_DEPTH) : 1;
   localparam logic [SLOT_W-1:0] LOG_LAST = SLOT_W'(LOG_DEPTH - 1);

   // shared divider geometry, two quotient bits per cycle
   localparam int DIV_W     = 32;
   localparam int DSR_W     = 16;
   localparam int DIV_STEPS = DIV_W / 2;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   // scaling constants
   localparam logic [UV_W-1:0]  UV_PER_STEP  = UV_W'(1221);
   localparam logic [DSR_W-1:0] SEC_PER_HOUR = DSR_W'(3600);
   localparam int               LOG_PERIOD   = 10;
   localparam int               UV_PER_MV    = 1000;
   localparam logic [DSR_W-1:0] LOG_DIVISOR  = DSR_W'(LOG_PERIOD * UV_PER_MV);
   localparam logic [VAL_W-1:0] END_KEY      = VAL_W'(16'hFFFE);
   localparam logic [SEC_W-1:0] SEC_PER_MIN  = SEC_W'(60);
   localparam logic [MIN_W-1:0] MINUTE_MAX   = '1;

   // register reset values
   localparam logic [ADC_W-1:0] PRESENCE_RESET = ADC_W'(30);
   localparam logic [ADC_W-1:0] STOP_RESET     = ADC_W'(2210);
   localparam logic [RES_W-1:0] LOAD_RESET     = RES_W'(2400);

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESENCE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_STOP     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_LOAD     = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_LOG_EN   = CSR_IDX_W'(3);

   typedef enum logic [1:0] {
      PH_WAIT,
      PH_RUN,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      DIV_SEL_MA,
      DIV_SEL_LOG,
      DIV_SEL_CAP
   } div_sel_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_DIV_MA,
      S_LOG_START,
      S_DIV_LOG,
      S_CAP_START,
      S_DIV_CAP,
      S_OUT
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic        load_sample;
      logic        set_run;
      logic        end_key;
      logic        div_start;
      div_sel_type div_sel;
      logic        accum;
      logic        log_commit;
      logic        cap_commit;
      logic        present;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      phase_type phase;
      logic      present_hit;
      logic      stop_hit;
      logic      log_tick;
      logic      div_done;
   } status_type;

   // second counts that close a ten-second log period
   function automatic logic is_log_second(input logic [SEC_W-1:0] s);
      logic hit;
      case (s)
         6'd10, 6'd20, 6'd30, 6'd40, 6'd50, 6'd60: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

[rtl/bdcm_div.sv]
// shared iterative unsigned divider, two quotient bits per cycle
module bdcm_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bdcm_pkg::DIV_W-1:0]    dividend,
   input  logic [bdcm_pkg::DSR_W-1:0]    divisor,
   output logic                          busy,
   output logic                          done,
   output logic [bdcm_pkg::DIV_W-1:0]    quotient
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [bdcm_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [bdcm_pkg::DIV_W-1:0]       dvd_ff, dvd_in;
   logic [bdcm_pkg::DSR_W-1:0]       dsr_ff, dsr_in;
   logic [bdcm_pkg::DSR_W-1:0]       rem_ff, rem_in;

   logic [bdcm_pkg::DSR_W:0] r1, r1s, r2, r2s, dsr_ext;
   logic                     ge1, ge2;

   // two restoring steps per cycle; quotient bits shift in behind the dividend
   always_comb begin
      dsr_ext = {1'b0, dsr_ff};
      r1      = {rem_ff, dvd_ff[bdcm_pkg::DIV_W-1]};
      ge1     = (r1 >= dsr_ext);
      r1s     = ge1 ? (r1 - dsr_ext) : r1;
      r2      = {r1s[bdcm_pkg::DSR_W-1:0], dvd_ff[bdcm_pkg::DIV_W-2]};
      ge2     = (r2 >= dsr_ext);
      r2s     = ge2 ? (r2 - dsr_ext) : r2;
   end

   // iteration control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[bdcm_pkg::DIV_W-3:0], ge1, ge2};
         rem_in = r2s[bdcm_pkg::DSR_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == bdcm_pkg::DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

[rtl/bdcm_datapath.sv]
// datapath: registers, discharge state, accumulators and result register
`include "battery_discharge_capacity_meter_assert.svh"

module bdcm_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  bdcm_pkg::cmd_type                 cmd,
   output bdcm_pkg::status_type              status,
   input  logic                              csr_wr_en,
   input  logic [bdcm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bdcm_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   input  logic [bdcm_pkg::ADC_W-1:0]        req_adc_sample,
   output logic                              rsp_load_on,
   output logic                              rsp_finished,
   output logic [bdcm_pkg::UV_W-1:0]         rsp_voltage_uv,
   output logic [bdcm_pkg::CAP_W-1:0]        rsp_capacity_mah,
   output logic [bdcm_pkg::MIN_W-1:0]        rsp_minutes_elapsed,
   output logic [bdcm_pkg::SEC_W-1:0]        rsp_seconds_elapsed,
   output logic                              rsp_log_write,
   output logic [bdcm_pkg::ADDR_W-1:0]       rsp_log_address,
   output logic [bdcm_pkg::VAL_W-1:0]        rsp_log_value,
   output logic                              rsp_log_full
);

   // configuration
   logic [bdcm_pkg::ADC_W-1:0] presence_ff, presence_in;
   logic [bdcm_pkg::ADC_W-1:0] stop_ff, stop_in;
   logic [bdcm_pkg::RES_W-1:0] load_ff, load_in;
   logic                       log_en_ff, log_en_in;

   // discharge state
   bdcm_pkg::phase_type           phase_ff, phase_in;
   logic [bdcm_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [bdcm_pkg::CHG_W-1:0]    charge_ff, charge_in;
   logic [bdcm_pkg::SEC_W-1:0]    second_ff, second_in;
   logic [bdcm_pkg::MIN_W-1:0]    minute_ff, minute_in;
   logic [bdcm_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic [bdcm_pkg::CAP_W-1:0]    cap_ff, cap_in;

   // per-sample working registers
   logic [bdcm_pkg::ADC_W-1:0]    sample_ff, sample_in;
   logic [bdcm_pkg::UV_W-1:0]     uv_ff, uv_in;
   logic                          rec_wr_ff, rec_wr_in;
   logic [bdcm_pkg::ADDR_W-1:0]   rec_addr_ff, rec_addr_in;
   logic [bdcm_pkg::VAL_W-1:0]    rec_val_ff, rec_val_in;

   // result register
   logic                          o_load_on_ff, o_finished_ff, o_wr_ff, o_full_ff;
   logic [bdcm_pkg::UV_W-1:0]     o_uv_ff;
   logic [bdcm_pkg::CAP_W-1:0]    o_cap_ff;
   logic [bdcm_pkg::MIN_W-1:0]    o_min_ff;
   logic [bdcm_pkg::SEC_W-1:0]    o_sec_ff;
   logic [bdcm_pkg::ADDR_W-1:0]   o_addr_ff;
   logic [bdcm_pkg::VAL_W-1:0]    o_val_ff;

   // divider hookup
   logic [bdcm_pkg::DIV_W-1:0]    div_dividend, div_q;
   logic [bdcm_pkg::DSR_W-1:0]    div_divisor, res_eff;
   logic                          div_busy, div_done;

   logic [bdcm_pkg::SEC_W-1:0]    second_next;
   logic [bdcm_pkg::CHG_W:0]      charge_sum;
   logic [31:0]                   slot_wide;

   bdcm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   // zero resistance counts as one milliohm
   assign res_eff = (load_ff == '0) ? bdcm_pkg::RES_W'(1) : load_ff;

   // divider operand select
   always_comb begin
      case (cmd.div_sel)
         bdcm_pkg::DIV_SEL_MA: begin
            div_dividend = bdcm_pkg::DIV_W'(uv_ff);
            div_divisor  = res_eff;
         end
         bdcm_pkg::DIV_SEL_LOG: begin
            div_dividend = bdcm_pkg::DIV_W'(sum_ff);
            div_divisor  = bdcm_pkg::LOG_DIVISOR;
         end
         bdcm_pkg::DIV_SEL_CAP: begin
            div_dividend = charge_ff;
            div_divisor  = bdcm_pkg::SEC_PER_HOUR;
         end
         default: begin
            div_dividend = charge_ff;
            div_divisor  = bdcm_pkg::SEC_PER_HOUR;
         end
      endcase
   end

   assign second_next = second_ff + 1'b1;
   assign charge_sum  = {1'b0, charge_ff} + {1'b0, div_q};
   assign slot_wide   = 32'(slot_ff);

   // status back to the controller
   always_comb begin
      status.phase       = phase_ff;
      status.present_hit = (sample_ff >= presence_ff);
      status.stop_hit    = (sample_ff <= stop_ff);
      status.log_tick    = bdcm_pkg::is_log_second(second_next);
      status.div_done    = div_done;
   end

   // configuration writes
   always_comb begin
      presence_in = presence_ff;
      stop_in     = stop_ff;
      load_in     = load_ff;
      log_en_in   = log_en_ff;
      if (csr_wr_en) begin
         case (csr_index)
            bdcm_pkg::CSR_PRESENCE: presence_in = csr_wr_data[bdcm_pkg::ADC_W-1:0];
            bdcm_pkg::CSR_STOP:     stop_in     = csr_wr_data[bdcm_pkg::ADC_W-1:0];
            bdcm_pkg::CSR_LOAD:     load_in     = csr_wr_data[bdcm_pkg::RES_W-1:0];
            bdcm_pkg::CSR_LOG_EN:   log_en_in   = csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // sample capture, phase changes, accumulation and log record
   always_comb begin
      sample_in   = sample_ff;
      uv_in       = uv_ff;
      rec_wr_in   = rec_wr_ff;
      rec_addr_in = rec_addr_ff;
      rec_val_in  = rec_val_ff;
      phase_in    = phase_ff;
      sum_in      = sum_ff;
      charge_in   = charge_ff;
      second_in   = second_ff;
      minute_in   = minute_ff;
      slot_in     = slot_ff;
      cap_in      = cap_ff;

      if (cmd.load_sample) begin
         sample_in   = req_adc_sample;
         uv_in       = bdcm_pkg::UV_W'(req_adc_sample) * bdcm_pkg::UV_PER_STEP;
         rec_wr_in   = 1'b0;
         rec_addr_in = slot_wide[bdcm_pkg::ADDR_W-1:0];
         rec_val_in  = '0;
      end

      // end of discharge wins over switching the load on
      if (cmd.end_key) begin
         phase_in   = bdcm_pkg::PH_DONE;
         rec_wr_in  = log_en_ff;
         rec_val_in = bdcm_pkg::END_KEY;
      end else if (cmd.set_run) begin
         phase_in = bdcm_pkg::PH_RUN;
      end

      // one discharge second: voltage sum, saturating charge, clock
      if (cmd.accum) begin
         sum_in    = sum_ff + bdcm_pkg::SUM_W'(uv_ff);
         charge_in = charge_sum[bdcm_pkg::CHG_W] ? '1 : charge_sum[bdcm_pkg::CHG_W-1:0];
         second_in = second_next;
         if (second_next >= bdcm_pkg::SEC_PER_MIN) begin
            second_in = '0;
            if (minute_ff != bdcm_pkg::MINUTE_MAX) begin
               minute_in = minute_ff + 1'b1;
            end
         end
      end

      // average millivolts record closes the ten-second period
      if (cmd.log_commit) begin
         rec_wr_in  = log_en_ff;
         rec_val_in = div_q[bdcm_pkg::VAL_W-1:0];
         sum_in     = '0;
         if (slot_ff != bdcm_pkg::LOG_LAST) begin
            slot_in = slot_ff + 1'b1;
         end
      end

      if (cmd.cap_commit) begin
         cap_in = div_q[bdcm_pkg::CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         presence_ff <= bdcm_pkg::PRESENCE_RESET;
         stop_ff     <= bdcm_pkg::STOP_RESET;
         load_ff     <= bdcm_pkg::LOAD_RESET;
         log_en_ff   <= 1'b0;
         phase_ff    <= bdcm_pkg::PH_WAIT;
         sum_ff      <= '0;
         charge_ff   <= '0;
         second_ff   <= '0;
         minute_ff   <= '0;
         slot_ff     <= '0;
         cap_ff      <= '0;
      end else begin
         presence_ff <= presence_in;
         stop_ff     <= stop_in;
         load_ff     <= load_in;
         log_en_ff   <= log_en_in;
         phase_ff    <= phase_in;
         sum_ff      <= sum_in;
         charge_ff   <= charge_in;
         second_ff   <= second_in;
         minute_ff   <= minute_in;
         slot_ff     <= slot_in;
         cap_ff      <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      uv_ff       <= uv_in;
      rec_wr_ff   <= rec_wr_in;
      rec_addr_ff <= rec_addr_in;
      rec_val_ff  <= rec_val_in;
   end

   // result register, loaded once the sample is fully processed
   always_ff @(posedge clock) begin
      if (cmd.present) begin
         o_load_on_ff  <= (phase_ff == bdcm_pkg::PH_RUN);
         o_finished_ff <= (phase_ff == bdcm_pkg::PH_DONE);
         o_uv_ff       <= uv_ff;
         o_cap_ff      <= cap_ff;
         o_min_ff      <= minute_ff;
         o_sec_ff      <= second_ff;
         o_wr_ff       <= rec_wr_ff;
         o_addr_ff     <= rec_addr_ff;
         o_val_ff      <= rec_val_ff;
         o_full_ff     <= (slot_ff == bdcm_pkg::LOG_LAST);
      end
   end

   assign rsp_load_on         = o_load_on_ff;
   assign rsp_finished        = o_finished_ff;
   assign rsp_voltage_uv      = o_uv_ff;
   assign rsp_capacity_mah    = o_cap_ff;
   assign rsp_minutes_elapsed = o_min_ff;
   assign rsp_seconds_elapsed = o_sec_ff;
   assign rsp_log_write       = o_wr_ff;
   assign rsp_log_address     = o_addr_ff;
   assign rsp_log_value       = o_val_ff;
   assign rsp_log_full        = o_full_ff;

   // checks
   `BDCM_ASSERT_IMPL(a_div_start_idle, cmd.div_start, !div_busy)
   `BDCM_ASSERT_IMPL(a_second_range, 1'b1, second_ff < bdcm_pkg::SEC_PER_MIN)
   `BDCM_ASSERT_IMPL(a_charge_monotonic, !$past(reset), charge_ff >= $past(charge_ff))
   `BDCM_ASSERT_NEXT(a_done_sticky, phase_ff == bdcm_pkg::PH_DONE, phase_ff == bdcm_pkg::PH_DONE)

endmodule

[rtl/bdcm_ctrl.sv]
// controller: sequences one sample through the datapath and the shared divider
`include "battery_discharge_capacity_meter_assert.svh"

module bdcm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bdcm_pkg::cmd_type      cmd,
   input  bdcm_pkg::status_type   status
);

   bdcm_pkg::ctrl_state_type state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     out_free;
   logic                     in_div;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == bdcm_pkg::S_IDLE);

   // any state that waits on the divider
   assign in_div = (state_ff == bdcm_pkg::S_DIV_MA) || (state_ff == bdcm_pkg::S_DIV_LOG) ||
                   (state_ff == bdcm_pkg::S_DIV_CAP);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.div_sel = bdcm_pkg::DIV_SEL_MA;
      case (state_ff)
         bdcm_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.load_sample = 1'b1;
               state_in        = bdcm_pkg::S_EVAL;
            end
         end
         bdcm_pkg::S_EVAL: begin
            case (status.phase)
               bdcm_pkg::PH_WAIT: begin
                  // presence tick also serves as the first stop check
                  if (status.present_hit) begin
                     cmd.set_run = 1'b1;
                     cmd.end_key = status.stop_hit;
                  end
                  state_in = bdcm_pkg::S_OUT;
               end
               bdcm_pkg::PH_RUN: begin
                  if (status.stop_hit) begin
                     cmd.end_key = 1'b1;
                     state_in    = bdcm_pkg::S_OUT;
                  end else begin
                     cmd.div_start = 1'b1;
                     cmd.div_sel   = bdcm_pkg::DIV_SEL_MA;
                     state_in      = bdcm_pkg::S_DIV_MA;
                  end
               end
               default: state_in = bdcm_pkg::S_OUT;
            endcase
         end
         bdcm_pkg::S_DIV_MA: begin
            if (status.div_done) begin
               cmd.accum = 1'b1;
               state_in  = status.log_tick ? bdcm_pkg::S_LOG_START : bdcm_pkg::S_CAP_START;
            end
         end
         bdcm_pkg::S_LOG_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = bdcm_pkg::DIV_SEL_LOG;
            state_in      = bdcm_pkg::S_DIV_LOG;
         end
         bdcm_pkg::S_DIV_LOG: begin
            if (status.div_done) begin
               cmd.log_commit = 1'b1;
               state_in       = bdcm_pkg::S_CAP_START;
            end
         end
         bdcm_pkg::S_CAP_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = bdcm_pkg::DIV_SEL_CAP;
            state_in      = bdcm_pkg::S_DIV_CAP;
         end
         bdcm_pkg::S_DIV_CAP: begin
            if (status.div_done) begin
               cmd.cap_commit = 1'b1;
               state_in       = bdcm_pkg::S_OUT;
            end
         end
         bdcm_pkg::S_OUT: begin
            if (out_free) begin
               cmd.present = 1'b1;
               state_in    = bdcm_pkg::S_IDLE;
            end
         end
         default: state_in = bdcm_pkg::S_IDLE;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.present) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdcm_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // checks
   `BDCM_ASSERT_IMPL(a_div_done_in_div_state, status.div_done, in_div)
   `BDCM_ASSERT_IMPL(a_rsp_from_out, $rose(rsp_valid_ff), $past(state_ff == bdcm_pkg::S_OUT))
   `BDCM_ASSERT_NEXT(a_present_returns_idle, cmd.present, state_ff == bdcm_pkg::S_IDLE)

endmodule

[rtl/battery_discharge_capacity_meter.sv]
// top level of the battery discharge capacity meter
//
// One req_ transfer carries the ADC sample of one one-second tick; one rsp_ transfer
// returns the load switch, finish flag, voltage, capacity, elapsed time and log record
// for that tick. A tick that only waits for the battery, ends the discharge or comes
// after the end passes without the divider; a discharging tick runs the current and
// capacity divisions, and on every tenth second also the log average division, through
// the one shared divider, which delivers two quotient bits per cycle. Each division is
// started, then iterates, then hands over its quotient, and the current, log average and
// capacity divisions run in turn. One tick is worked at a time; the next one can be taken
// as soon as the current result sits in the output register, even before that result is
// taken, and a finished tick waits while an earlier result is still held. Configuration
// writes apply from the next tick on and must be made while the block is idle. There is
// no clearing pass after reset.
module battery_discharge_capacity_meter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bdcm_pkg::ADC_W-1:0]        req_adc_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_load_on,
   output logic                              rsp_finished,
   output logic [bdcm_pkg::UV_W-1:0]         rsp_voltage_uv,
   output logic [bdcm_pkg::CAP_W-1:0]        rsp_capacity_mah,
   output logic [bdcm_pkg::MIN_W-1:0]        rsp_minutes_elapsed,
   output logic [bdcm_pkg::SEC_W-1:0]        rsp_seconds_elapsed,
   output logic                              rsp_log_write,
   output logic [bdcm_pkg::ADDR_W-1:0]       rsp_log_address,
   output logic [bdcm_pkg::VAL_W-1:0]        rsp_log_value,
   output logic                              rsp_log_full,
   input  logic                              csr_wr_en,
   input  logic [bdcm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bdcm_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   bdcm_pkg::cmd_type    cmd;
   bdcm_pkg::status_type status;

   // sequencing
   bdcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // arithmetic, state and result register
   bdcm_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .req_adc_sample      (req_adc_sample),
      .rsp_load_on         (rsp_load_on),
      .rsp_finished        (rsp_finished),
      .rsp_voltage_uv      (rsp_voltage_uv),
      .rsp_capacity_mah    (rsp_capacity_mah),
      .rsp_minutes_elapsed (rsp_minutes_elapsed),
      .rsp_seconds_elapsed (rsp_seconds_elapsed),
      .rsp_log_write       (rsp_log_write),
      .rsp_log_address     (rsp_log_address),
      .rsp_log_value       (rsp_log_value),
      .rsp_log_full        (rsp_log_full)
   );

endmodule

[bench/discharge_meter_checker.sv]
`timescale 1ns / 1ps
// transfer monitor, tick predictor and result comparison for the discharge meter
module discharge_meter_checker
   import bdcm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [ADC_W-1:0]      req_adc_sample,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_load_on,
   input  logic                  rsp_finished,
   input  logic [UV_W-1:0]       rsp_voltage_uv,
   input  logic [CAP_W-1:0]      rsp_capacity_mah,
   input  logic [MIN_W-1:0]      rsp_minutes_elapsed,
   input  logic [SEC_W-1:0]      rsp_seconds_elapsed,
   input  logic                  rsp_log_write,
   input  logic [ADDR_W-1:0]     rsp_log_address,
   input  logic [VAL_W-1:0]      rsp_log_value,
   input  logic                  rsp_log_full,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output int                    mismatch_count,
   output int                    pending,
   output int                    checked_count,
   output int                    record_count
);

   // one tick report as the meter should return it
   typedef struct {
      logic              load_on;
      logic              finished;
      logic [UV_W-1:0]   voltage_uv;
      logic [CAP_W-1:0]  capacity_mah;
      logic [MIN_W-1:0]  minutes;
      logic [SEC_W-1:0]  seconds;
      logic              log_write;
      logic [ADDR_W-1:0] log_address;
      logic [VAL_W-1:0]  log_value;
      logic              log_full;
   } tick_report;

   tick_report expected_reports[$];

   // register copy
   logic [ADC_W-1:0] presence_lvl;
   logic [ADC_W-1:0] stop_lvl;
   logic [RES_W-1:0] load_mohm;
   logic             log_en;

   // discharge state copy
   phase_type         meter_phase;
   logic [SUM_W-1:0]  volt_sum;
   logic [CHG_W-1:0]  charge_mas;
   logic [SEC_W-1:0]  sec_cnt;
   logic [MIN_W-1:0]  min_cnt;
   logic [SLOT_W-1:0] slot;

   // advance the meter by one second and form its report
   task automatic predict_tick(input logic [ADC_W-1:0] code, output tick_report r);
      logic [31:0]       uv;
      logic [31:0]       ohms;
      logic [31:0]       milliamps;
      logic [31:0]       avg_mv;
      logic [SLOT_W-1:0] at_slot;
      logic              wr;
      logic [VAL_W-1:0]  val;
      uv = 32'(code) * 32'(UV_PER_STEP);
      wr = 1'b0;
      at_slot = slot;
      val = '0;
      case (meter_phase)
         PH_WAIT: begin
            if (code >= presence_lvl) begin
               meter_phase = PH_RUN;
               // the presence sample also serves as the first stop check
               if (code <= stop_lvl) begin
                  meter_phase = PH_DONE;
                  wr = log_en;
                  val = END_KEY;
               end
            end
         end
         PH_RUN: begin
            if (code <= stop_lvl) begin
               // end of discharge, key goes to the current slot
               meter_phase = PH_DONE;
               wr = log_en;
               val = END_KEY;
            end else begin
               ohms = (load_mohm == '0) ? 32'd1 : 32'(load_mohm);
               milliamps = uv / ohms;
               volt_sum = volt_sum + SUM_W'(uv);
               // saturating charge accumulation
               charge_mas = (charge_mas > ~milliamps) ? '1 : charge_mas + milliamps;
               sec_cnt = sec_cnt + 1'b1;
               if (sec_cnt % LOG_PERIOD == 0) begin
                  wr = log_en;
                  at_slot = slot;
                  avg_mv = 32'(volt_sum) / (LOG_PERIOD * UV_PER_MV);
                  val = VAL_W'(avg_mv);
                  if (slot != LOG_LAST) slot = slot + 1'b1;
                  volt_sum = '0;
               end
               if (sec_cnt >= SEC_PER_MIN) begin
                  sec_cnt = '0;
                  if (min_cnt != MINUTE_MAX) min_cnt = min_cnt + 1'b1;
               end
            end
         end
         default: meter_phase = PH_DONE;
      endcase
      r.load_on = (meter_phase == PH_RUN);
      r.finished = (meter_phase == PH_DONE);
      r.voltage_uv = UV_W'(uv);
      r.capacity_mah = CAP_W'(charge_mas / 32'(SEC_PER_HOUR));
      r.minutes = min_cnt;
      r.seconds = sec_cnt;
      r.log_write = wr;
      r.log_address = ADDR_W'(at_slot);
      r.log_value = val;
      r.log_full = (slot == LOG_LAST);
   endtask

   // compare one field, report only the first few
   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch on %s in result %0d: expected %0d, got %0d",
                     field, checked_count, want, got);
      end
   endtask

   // watch the transfers and the register writes
   always @(posedge clock) begin
      tick_report want;
      tick_report fresh;
      if (reset) begin
         expected_reports.delete();
         presence_lvl = PRESENCE_RESET;
         stop_lvl = STOP_RESET;
         load_mohm = LOAD_RESET;
         log_en = 1'b0;
         meter_phase = PH_WAIT;
         volt_sum = '0;
         charge_mas = '0;
         sec_cnt = '0;
         min_cnt = '0;
         slot = '0;
         mismatch_count = 0;
         checked_count = 0;
         record_count = 0;
      end else begin
         // result transfer against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            checked_count++;
            if (rsp_log_write === 1'b1) record_count++;
            if (expected_reports.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result %0d arrived with no tick outstanding", checked_count);
            end else begin
               want = expected_reports.pop_front();
               check_field("load_on", want.load_on, rsp_load_on);
               check_field("finished", want.finished, rsp_finished);
               check_field("voltage_uv", want.voltage_uv, rsp_voltage_uv);
               check_field("capacity_mah", want.capacity_mah, rsp_capacity_mah);
               check_field("minutes_elapsed", want.minutes, rsp_minutes_elapsed);
               check_field("seconds_elapsed", want.seconds, rsp_seconds_elapsed);
               check_field("log_write", want.log_write, rsp_log_write);
               check_field("log_address", want.log_address, rsp_log_address);
               check_field("log_value", want.log_value, rsp_log_value);
               check_field("log_full", want.log_full, rsp_log_full);
            end
         end
         // sample transfer
         if (req_valid && req_ready) begin
            predict_tick(req_adc_sample, fresh);
            expected_reports.push_back(fresh);
         end
         // register write, seen from the next tick on
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PRESENCE: presence_lvl = csr_wr_data[ADC_W-1:0];
               CSR_STOP:     stop_lvl = csr_wr_data[ADC_W-1:0];
               CSR_LOAD:     load_mohm = csr_wr_data[RES_W-1:0];
               CSR_LOG_EN:   log_en = csr_wr_data[0];
               default:      ;
            endcase
         end
      end
      pending <= expected_reports.size();
   end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// top of the discharge meter bench: clock, reset, stimulus and verdict
module tb_top;
   import bdcm_pkg::*;

   // high-current ticks driven at the end with no idling
   localparam int LONG_HAUL = 50;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [ADC_W-1:0]      req_adc_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_load_on;
   logic                  rsp_finished;
   logic [UV_W-1:0]       rsp_voltage_uv;
   logic [CAP_W-1:0]      rsp_capacity_mah;
   logic [MIN_W-1:0]      rsp_minutes_elapsed;
   logic [SEC_W-1:0]      rsp_seconds_elapsed;
   logic                  rsp_log_write;
   logic [ADDR_W-1:0]     rsp_log_address;
   logic [VAL_W-1:0]      rsp_log_value;
   logic                  rsp_log_full;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   logic idling = 1'b1;
   int   stall_left = 0;
   int   sent_total = 0;
   int   mismatch_count;
   int   pending;
   int   checked_count;
   int   record_count;

   battery_discharge_capacity_meter dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_adc_sample      (req_adc_sample),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_load_on         (rsp_load_on),
      .rsp_finished        (rsp_finished),
      .rsp_voltage_uv      (rsp_voltage_uv),
      .rsp_capacity_mah    (rsp_capacity_mah),
      .rsp_minutes_elapsed (rsp_minutes_elapsed),
      .rsp_seconds_elapsed (rsp_seconds_elapsed),
      .rsp_log_write       (rsp_log_write),
      .rsp_log_address     (rsp_log_address),
      .rsp_log_value       (rsp_log_value),
      .rsp_log_full        (rsp_log_full),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data)
   );

   discharge_meter_checker meter_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_adc_sample      (req_adc_sample),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_load_on         (rsp_load_on),
      .rsp_finished        (rsp_finished),
      .rsp_voltage_uv      (rsp_voltage_uv),
      .rsp_capacity_mah    (rsp_capacity_mah),
      .rsp_minutes_elapsed (rsp_minutes_elapsed),
      .rsp_seconds_elapsed (rsp_seconds_elapsed),
      .rsp_log_write       (rsp_log_write),
      .rsp_log_address     (rsp_log_address),
      .rsp_log_value       (rsp_log_value),
      .rsp_log_full        (rsp_log_full),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .mismatch_count      (mismatch_count),
      .pending             (pending),
      .checked_count       (checked_count),
      .record_count        (record_count)
   );

   // 100 MHz clock
   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop well past the slowest legal run
   initial begin
      #40_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // result side back-pressure in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idling && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 5);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // one sample transfer, with an occasional gap ahead of it
   task automatic send_sample(input logic [ADC_W-1:0] code);
      int gap;
      if (idling && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_adc_sample <= code;
      do @(posedge clock); while (!req_ready);
      sent_total++;
   endtask

   // hold the sender until every predicted result has been taken
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // write all four registers, junk in the unused data bits
   task automatic apply_config(input logic [ADC_W-1:0] present_lvl,
                               input logic [ADC_W-1:0] stop_lvl,
                               input logic [RES_W-1:0] load_mohm,
                               input logic             log_on);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_PRESENCE;
      csr_wr_data <= {4'($urandom), present_lvl};
      @(posedge clock);
      csr_index <= CSR_STOP;
      csr_wr_data <= {4'($urandom), stop_lvl};
      @(posedge clock);
      csr_index <= CSR_LOAD;
      csr_wr_data <= load_mohm;
      @(posedge clock);
      csr_index <= CSR_LOG_EN;
      csr_wr_data <= {15'($urandom), log_on};
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // stimulus and verdict
   initial begin
      int               seg;
      logic [ADC_W-1:0] stop_lvl;
      logic [RES_W-1:0] load_mohm;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset thresholds: samples below presence leave the meter waiting
      send_sample(12'd0);
      send_sample(12'd29);

      // top presence level, zero stop level, zero resistance, logging on
      wait_drained();
      apply_config(12'd4095, 12'd0, 16'd0, 1'b1);
      send_sample(12'd4094);
      send_sample(12'd4095);
      send_sample(12'd4095); send_sample(12'd1);    send_sample(12'd2048);
      send_sample(12'd2730); send_sample(12'd1365); send_sample(12'd4095);
      send_sample(12'd4095); send_sample(12'd1);    send_sample(12'd3000);
      send_sample(12'd4095); send_sample(12'd100);  send_sample(12'd2211);

      // largest load, logging off across the second log period
      wait_drained();
      apply_config(12'd0, 12'd2210, 16'hFFFF, 1'b0);
      send_sample(12'd2211); send_sample(12'd4095); send_sample(12'd2211);
      send_sample(12'd3000); send_sample(12'd2500); send_sample(12'd4095);
      send_sample(12'd2211); send_sample(12'd3500); send_sample(12'd4095);

      // random discharge segments, settings changed while idle
      for (seg = 0; seg < 8; seg++) begin
         wait_drained();
         stop_lvl = ADC_W'($urandom_range(0, 1500));
         case ($urandom_range(0, 3))
            0:       load_mohm = '0;
            1:       load_mohm = RES_W'(1);
            2:       load_mohm = '1;
            default: load_mohm = RES_W'($urandom_range(1, 65535));
         endcase
         apply_config(ADC_W'($urandom_range(0, 4095)), stop_lvl, load_mohm,
                      1'($urandom_range(0, 1)));
         idling <= (seg % 3 != 2);
         repeat (40) send_sample(ADC_W'($urandom_range(32'(stop_lvl) + 1, 4095)));
      end

      // closing run of high-current ticks, no idling on either side
      wait_drained();
      idling <= 1'b0;
      apply_config(ADC_W'($urandom_range(0, 4095)), 12'd0, 16'd0, 1'b1);
      repeat (LONG_HAUL) send_sample(ADC_W'($urandom_range(3000, 4095)));

      // stop at the top threshold, then samples after the end
      wait_drained();
      apply_config(ADC_W'($urandom_range(0, 4095)), 12'd4095,
                   RES_W'($urandom_range(0, 65535)), 1'b1);
      send_sample(12'd4095);
      send_sample(12'd0);
      send_sample(12'd4095);
      send_sample(ADC_W'($urandom_range(0, 4095)));

      wait_drained();
      repeat (64) @(posedge clock);

      $display("drove %0d samples: waiting, presence, discharge over minutes and log periods",
               sent_total);
      $display("then stop and ticks after the end; compared %0d results, %0d with log strobe",
               checked_count, record_count);
      if (mismatch_count == 0 && pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
